// ===== sv/stack_with_bottom_k_increment_assert.svh =====
// Assertion macros used by the stack controller (sbk_ctrl).
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STACK_WITH_BOTTOM_K_INCREMENT_ASSERT_SVH
`define STACK_WITH_BOTTOM_K_INCREMENT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbk_pkg.sv =====
`timescale 1ns / 1ps

package sbk_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int SIZE_BITS   = $clog2(STACK_DEPTH + 1);
  localparam int COUNT_BITS  = 11;
  localparam int CMP_BITS    = (SIZE_BITS > COUNT_BITS) ? SIZE_BITS : COUNT_BITS;
  localparam int ACT_BITS    = 2;
  localparam int STATUS_BITS = 2;

  // Stream word widths, padded to whole bytes
  localparam int IN_FIELD_BITS = VALUE_BITS + COUNT_BITS + VALUE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS  = ACT_BITS;
  localparam int OUT_USER_BITS = 1 + STATUS_BITS;

  // Operation codes
  localparam logic [ACT_BITS-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_ADD  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD_COUNT = 2'd3;

  // Memory requests from the controller; one read address serves both RAMs
  typedef struct packed {
    logic                  val_we;
    logic [ADDR_BITS-1:0]  val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic                  tag_we;
    logic [ADDR_BITS-1:0]  tag_waddr;
    logic [VALUE_BITS-1:0] tag_wdata;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
  } mem_req_t;

endpackage

// ===== sv/sbk_ram.sv =====
`timescale 1ns / 1ps

module sbk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sbk_ctrl.sv =====
`timescale 1ns / 1ps
`include "stack_with_bottom_k_increment_assert.svh"

module sbk_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sbk_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic [sbk_pkg::IN_USER_BITS-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sbk_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  output logic [sbk_pkg::OUT_USER_BITS-1:0]   m_tuser,
  output sbk_pkg::mem_req_t                   mem_req,
  input  logic [sbk_pkg::VALUE_BITS-1:0]      val_rdata,
  input  logic [sbk_pkg::VALUE_BITS-1:0]      tag_rdata
);

  localparam int VB = sbk_pkg::VALUE_BITS;
  localparam int AB = sbk_pkg::ADDR_BITS;
  localparam int SB = sbk_pkg::SIZE_BITS;
  localparam int CB = sbk_pkg::CMP_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;

  // Held input word
  logic                            item_valid;
  logic [sbk_pkg::ACT_BITS-1:0]    act;
  logic [VB-1:0]                   push_value;
  logic [sbk_pkg::COUNT_BITS-1:0]  inc_count;
  logic [VB-1:0]                   inc_amount;

  // Stack size and cached top entry (its tag lives only here)
  logic [SB-1:0] size, size_next;
  logic [VB-1:0] top_value, top_value_next;
  logic [VB-1:0] top_tag, top_tag_next;

  // Output register
  logic [VB-1:0]                    out_sum, res_sum;
  logic                             out_empty, res_empty;
  logic [sbk_pkg::STATUS_BITS-1:0]  out_status, res_status;
  logic                             out_load, out_free;

  logic          empty, full;
  logic [CB-1:0] k_ext, size_ext, k_m1;
  logic [SB-1:0] size_m1, size_m2;
  logic [VB-1:0] top_sum_cur, rep_sum;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !item_valid || out_load;

  assign empty       = (size == '0);
  assign full        = (size == SB'(sbk_pkg::STACK_DEPTH));
  assign k_ext       = CB'(inc_count);
  assign size_ext    = CB'(size);
  assign k_m1        = k_ext - CB'(1);
  assign size_m1     = size - SB'(1);
  assign size_m2     = size - SB'(2);
  assign top_sum_cur = top_value + top_tag;
  assign rep_sum     = empty ? '0 : top_sum_cur;

  // Decode the held word, drive memory requests and the result
  always_comb begin
    state_next     = state;
    size_next      = size;
    top_value_next = top_value;
    top_tag_next   = top_tag;
    mem_req        = '0;
    out_load       = 1'b0;
    res_sum        = rep_sum;
    res_empty      = empty;
    res_status     = sbk_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (item_valid && out_free) begin
          case (act)
            sbk_pkg::ACT_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                res_status = sbk_pkg::ST_PUSH_FULL;
              end else begin
                mem_req.val_we    = 1'b1;
                mem_req.val_waddr = size[AB-1:0];
                mem_req.val_wdata = push_value;
                // Flush the old top tag before it leaves the cache
                mem_req.tag_we    = !empty;
                mem_req.tag_waddr = size_m1[AB-1:0];
                mem_req.tag_wdata = top_tag;
                top_value_next    = push_value;
                top_tag_next      = '0;
                size_next         = size + SB'(1);
                res_sum           = push_value;
                res_empty         = 1'b0;
              end
            end
            sbk_pkg::ACT_POP: begin
              if (empty) begin
                out_load   = 1'b1;
                res_status = sbk_pkg::ST_POP_EMPTY;
              end else if (size == SB'(1)) begin
                out_load  = 1'b1;
                size_next = '0;
                res_sum   = '0;
                res_empty = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = size_m2[AB-1:0];
                state_next      = S_READ;
              end
            end
            sbk_pkg::ACT_ADD: begin
              if (inc_count == '0 || k_ext > size_ext) begin
                out_load   = 1'b1;
                res_status = sbk_pkg::ST_BAD_COUNT;
              end else if (k_ext == size_ext) begin
                out_load     = 1'b1;
                top_tag_next = top_tag + inc_amount;
                res_sum      = top_sum_cur + inc_amount;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = k_m1[AB-1:0];
                state_next      = S_READ;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // Output slot was freed when the read was issued
        out_load   = 1'b1;
        state_next = S_IDLE;
        res_empty  = 1'b0;
        if (act == sbk_pkg::ACT_POP) begin
          top_value_next = val_rdata;
          top_tag_next   = tag_rdata + top_tag;
          size_next      = size_m1;
          res_sum        = val_rdata + tag_rdata + top_tag;
        end else begin
          mem_req.tag_we    = 1'b1;
          mem_req.tag_waddr = k_m1[AB-1:0];
          mem_req.tag_wdata = tag_rdata + inc_amount;
          res_sum           = top_sum_cur;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size       <= '0;
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      size  <= size_next;
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
      end else if (out_load) begin
        item_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_value <= top_value_next;
    top_tag   <= top_tag_next;
    if (s_tvalid && s_tready) begin
      act        <= s_tuser[sbk_pkg::ACT_BITS-1:0];
      push_value <= s_tdata[VB-1:0];
      inc_count  <= s_tdata[VB+sbk_pkg::COUNT_BITS-1:VB];
      inc_amount <= s_tdata[2*VB+sbk_pkg::COUNT_BITS-1:VB+sbk_pkg::COUNT_BITS];
    end
    if (out_load) begin
      out_sum    <= res_sum;
      out_empty  <= res_empty;
      out_status <= res_status;
    end
  end

  assign m_tdata = sbk_pkg::OUT_DATA_BITS'(out_sum);
  assign m_tuser = {out_status, out_empty};

  `SBK_ASSERT_NOW(a_read_slot_free, state == S_READ, !m_tvalid, "result pending during read")
  `SBK_ASSERT_NOW(a_read_has_item, state == S_READ, item_valid, "read without a held word")
  `SBK_ASSERT_NEXT(a_empty_flag, out_load, out_empty == (size == '0), "empty flag mismatch")
  `SBK_ASSERT_NEXT(a_size_bound, 1'b1, size <= SB'(sbk_pkg::STACK_DEPTH), "size overflow")

endmodule

// ===== sv/stack_with_bottom_k_increment.sv =====
`timescale 1ns / 1ps
// Stack of signed words with push, pop and add-to-bottom-k (lazy tags).
// Input channel s_*: s_tuser carries the action (0 push, 1 pop, 2 add);
// s_tdata carries push_value, inc_count and inc_amount. Output channel m_*:
// m_tdata carries top_sum; m_tuser carries is_empty and status.
// Every input word yields exactly one result word, in order.
// Timing: a word is held in an input register, then executed. Push, empty or
// single-entry pop, error cases, and an add that reaches the top entry finish
// from the cached top once the output register is free. A pop of a deeper
// stack and an add below the top read the tag RAM, whose registered read
// adds the READ state, so those finish there. For every word, the next word
// is taken in the cycle that finishes the held one.
// The top entry's value and tag are cached in registers; the RAMs hold the
// entries below it, so a pop needs only one read of each RAM.
// Reset clears the stack size and both handshakes; RAM contents are left
// as they are and are never read before being written.
// When m_tready is low the finished result holds in the output register and
// one more input word is still accepted into the input register; further
// input waits until the output register frees.
module stack_with_bottom_k_increment (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] push_value, [42:32] inc_count, [74:43] inc_amount, rest zero
  input  logic [sbk_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // [1:0] action
  input  logic [sbk_pkg::IN_USER_BITS-1:0]  s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] top_sum
  output logic [sbk_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // [0] is_empty, [2:1] status
  output logic [sbk_pkg::OUT_USER_BITS-1:0] m_tuser
);

  sbk_pkg::mem_req_t                mem_req;
  logic [sbk_pkg::VALUE_BITS-1:0]   val_rdata;
  logic [sbk_pkg::VALUE_BITS-1:0]   tag_rdata;

  // Entry values
  sbk_ram #(
    .WIDTH (sbk_pkg::VALUE_BITS),
    .DEPTH (sbk_pkg::STACK_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (mem_req.val_we),
    .waddr (mem_req.val_waddr),
    .wdata (mem_req.val_wdata),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (val_rdata)
  );

  // Entry increment tags
  sbk_ram #(
    .WIDTH (sbk_pkg::VALUE_BITS),
    .DEPTH (sbk_pkg::STACK_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_req.tag_we),
    .waddr (mem_req.tag_waddr),
    .wdata (mem_req.tag_wdata),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (tag_rdata)
  );

  sbk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .mem_req   (mem_req),
    .val_rdata (val_rdata),
    .tag_rdata (tag_rdata)
  );

endmodule

// ===== sim/stack_with_bottom_k_increment_checker.sv =====
`timescale 1ns / 1ps

module stack_with_bottom_k_increment_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // [31:0] push_value, [42:32] inc_count, [74:43] inc_amount, rest zero
  input  logic [sbk_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // [1:0] action
  input  logic [sbk_pkg::IN_USER_BITS-1:0]  s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] top_sum
  input  logic [sbk_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // [0] is_empty, [2:1] status
  input  logic [sbk_pkg::OUT_USER_BITS-1:0] m_tuser,
  output int                                mismatch_count,
  output int                                pending_results
);
  import sbk_pkg::*;

  localparam int COUNT_LO  = VALUE_BITS;
  localparam int AMOUNT_LO = VALUE_BITS + COUNT_BITS;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  top_sum;
    logic                   is_empty;
    logic [STATUS_BITS-1:0] status;
  } stack_result_t;

  // Shadow stack: entry values, lazy tags and fill level
  logic [VALUE_BITS-1:0] value_mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] tag_mem [STACK_DEPTH];
  int unsigned           depth_now;
  stack_result_t         expected_results[$];
  int                    errors = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns MISMATCH %s", $time, msg);
    errors++;
  endtask

  // Apply one operation to the shadow stack and queue the word it must produce
  task automatic apply_stack_op(input logic [ACT_BITS-1:0]   act,
                                input logic [VALUE_BITS-1:0] value,
                                input logic [COUNT_BITS-1:0] count,
                                input logic [VALUE_BITS-1:0] amount);
    stack_result_t res;
    res.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (depth_now >= STACK_DEPTH) begin
          res.status = ST_PUSH_FULL;
        end else begin
          value_mem[depth_now] = value;
          tag_mem[depth_now]   = '0;
          depth_now++;
        end
      end
      ACT_POP: begin
        if (depth_now == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          // hand the popped tag down to the new top
          if (depth_now > 1) begin
            tag_mem[depth_now-2] = tag_mem[depth_now-2] + tag_mem[depth_now-1];
          end
          depth_now--;
        end
      end
      ACT_ADD: begin
        if (count == 0 || count > depth_now) begin
          res.status = ST_BAD_COUNT;
        end else begin
          tag_mem[count-1] = tag_mem[count-1] + amount;
        end
      end
      default: ;
    endcase
    // true top value is its stored value plus its own tag
    if (depth_now == 0) begin
      res.top_sum  = '0;
      res.is_empty = 1'b1;
    end else begin
      res.top_sum  = value_mem[depth_now-1] + tag_mem[depth_now-1];
      res.is_empty = 1'b0;
    end
    expected_results.insert(expected_results.size(), res);
  endtask

  // Compare a result word with the oldest expectation, field by field
  task automatic check_result();
    stack_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected: top_sum %0d",
                                $signed(m_tdata[VALUE_BITS-1:0])));
    end else begin
      want = expected_results.pop_front();
      if (m_tdata[VALUE_BITS-1:0] !== want.top_sum) begin
        report_mismatch($sformatf("top_sum got %0d want %0d",
                                  $signed(m_tdata[VALUE_BITS-1:0]), $signed(want.top_sum)));
      end
      if (m_tuser[0] !== want.is_empty) begin
        report_mismatch($sformatf("is_empty got %b want %b", m_tuser[0], want.is_empty));
      end
      if (m_tuser[STATUS_BITS:1] !== want.status) begin
        report_mismatch($sformatf("status got %0d want %0d",
                                  m_tuser[STATUS_BITS:1], want.status));
      end
    end
  endtask

  // Watch both channels; take the input side first so order is kept
  always @(posedge clk) begin
    if (rst) begin
      depth_now = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        apply_stack_op(s_tuser[ACT_BITS-1:0], s_tdata[VALUE_BITS-1:0],
                       s_tdata[COUNT_LO +: COUNT_BITS], s_tdata[AMOUNT_LO +: VALUE_BITS]);
      end
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        check_result();
      end
    end
    pending_results <= expected_results.size();
    mismatch_count  <= errors;
  end

endmodule

// ===== sim/stack_with_bottom_k_increment_tb.sv =====
`timescale 1ns / 1ps

module stack_with_bottom_k_increment_tb;
  import sbk_pkg::*;

  // Action code that the block treats as a no-op
  localparam logic [ACT_BITS-1:0] ACT_NONE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;
  logic [IN_USER_BITS-1:0]  s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [OUT_USER_BITS-1:0] m_tuser;
  int                       mismatch_count;
  int                       pending_results;
  bit                       idle_on = 1'b1;
  int                       stack_fill = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stack_with_bottom_k_increment dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  stack_with_bottom_k_increment_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Favor the wrap-around corners now and then
  function automatic logic [VALUE_BITS-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [ACT_BITS-1:0]   act,
                           input logic [VALUE_BITS-1:0] value,
                           input logic [COUNT_BITS-1:0] count,
                           input logic [VALUE_BITS-1:0] amount);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}}, amount, count, value};
    do @(posedge clk); while (s_tready !== 1'b1);
    // track the fill level only to steer counts and phases
    if (act == ACT_PUSH && stack_fill < STACK_DEPTH) begin
      stack_fill++;
    end else if (act == ACT_POP && stack_fill > 0) begin
      stack_fill--;
    end
  endtask

  // Random operation; counts mostly valid, with edges and bad counts mixed in
  task automatic send_random_op(input int push_pct, input int pop_pct);
    int                    pick;
    logic [COUNT_BITS-1:0] count;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       count = '0;
      1:       count = COUNT_BITS'(stack_fill + 1);
      2:       count = COUNT_BITS'($urandom_range(0, 2047));
      3:       count = COUNT_BITS'(stack_fill);
      4:       count = COUNT_BITS'(1);
      default: count = COUNT_BITS'($urandom_range(1, (stack_fill > 1) ? stack_fill : 1));
    endcase
    if (pick < push_pct) begin
      send_word(ACT_PUSH, draw_value(), COUNT_BITS'($urandom), $urandom);
    end else if (pick < push_pct + pop_pct) begin
      send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    end else if (pick < 98) begin
      send_word(ACT_ADD, $urandom, count, draw_value());
    end else begin
      send_word(ACT_NONE, $urandom, COUNT_BITS'($urandom), $urandom);
    end
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Result side: random stall before each word
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ACT_PUSH;
    rst      <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: pop, add and no-op all report empty
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(1), 32'd9);
    send_word(ACT_NONE, $urandom, COUNT_BITS'($urandom), $urandom);
    // Push value extremes
    send_word(ACT_PUSH, 32'h7FFF_FFFF, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_PUSH, 32'h8000_0000, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_PUSH, 32'h0000_0000, '1, '1);
    send_word(ACT_PUSH, 32'hFFFF_FFFF, '0, '0);
    // Bad counts: zero, one past the top, field maximum (beyond depth)
    send_word(ACT_ADD, $urandom, '0, 32'd5);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(5), 32'd5);
    send_word(ACT_ADD, $urandom, '1, 32'h7FFF_FFFF);
    // Valid adds at the top and below it, wrapping amounts
    send_word(ACT_ADD, $urandom, COUNT_BITS'(4), 32'd1);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(1), 32'h7FFF_FFFF);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(2), 32'h8000_0000);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(3), 32'hFFFF_FFFF);
    send_word(ACT_NONE, $urandom, COUNT_BITS'($urandom), $urandom);
    // Pops fold tags downward, then down to a single entry and empty
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(STACK_DEPTH), 32'd3);
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_ADD, $urandom, COUNT_BITS'(1), 32'h8000_0000);
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_POP, $urandom, COUNT_BITS'($urandom), $urandom);
    send_word(ACT_PUSH, 32'h1234_5678, '1, '1);
    send_word(ACT_POP, '1, '1, '1);
    wait_for_results();

    // Shallow random walk, often back to empty
    for (int i = 0; i < 80; i++) begin
      if (i % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_random_op(45, 35);
    end
    wait_for_results();

    // Climb to full with adds spread across the depth
    idle_on = 1'b1;
    while (stack_fill < STACK_DEPTH) begin
      send_random_op(92, 2);
    end
    // Hover at full: push on full, adds on the whole stack
    for (int i = 0; i < 40; i++) begin
      send_random_op(45, 10);
    end
    // Unwind, folding deep tags
    for (int i = 0; i < 70; i++) begin
      if (i % 35 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_random_op(25, 60);
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== stack_with_bottom_k_increment.f =====
+incdir+sv
sv/sbk_pkg.sv
sv/sbk_ram.sv
sv/sbk_ctrl.sv
sv/stack_with_bottom_k_increment.sv
sim/stack_with_bottom_k_increment_checker.sv
sim/stack_with_bottom_k_increment_tb.sv
